@@ design/cpa_pkg.sv @@
package cpa_pkg;

  localparam int NUM_PAGES = 32;
  localparam int PAGE_KB   = 4;

  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int CNT_W  = PAGE_W + 1;

  localparam int ID_W     = 8;
  localparam int SIZE_W   = 12;
  localparam int STATUS_W = 2;
  localparam int START_W  = 5;
  localparam int USED_W   = 11;
  localparam int FREED_W  = 6;
  localparam int FRAG_W   = 5;
  localparam int FREE_W   = 6;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_KILL  = 2'd1;
  localparam logic [1:0] CMD_COUNT = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 2'd2;

  typedef logic [PAGE_W-1:0] page_idx_t;
  typedef logic [CNT_W-1:0]  page_cnt_t;

  typedef struct packed {
    logic            taken;
    logic [ID_W-1:0] owner;
  } page_entry_t;

  // Per-pass and per-page strobes from the sequencer to the run scanner.
  typedef struct packed {
    logic      init;
    logic      step;
    logic      page_free;
    page_idx_t page;
    logic      finish;
  } scan_ctl_t;

  typedef struct packed {
    logic      found;
    page_idx_t best_start;
    page_cnt_t best_len;
    page_cnt_t frags;
    page_cnt_t frees;
  } scan_res_t;

endpackage

@@ design/cpa_page_ram.sv @@
module cpa_page_ram
  import cpa_pkg::*;
(
  input  logic        clk,
  input  logic        we,
  input  page_idx_t   waddr,
  input  page_entry_t wdata,
  input  page_idx_t   raddr,
  output page_entry_t rdata
);

  page_entry_t mem [NUM_PAGES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/cpa_run_scan.sv @@
module cpa_run_scan
  import cpa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  scan_ctl_t         ctl,
  input  logic [USED_W-1:0] need,
  input  logic              best_fit,
  output scan_res_t         res
);

  logic      prev_free;
  page_idx_t cur_start;
  page_cnt_t cur_len;
  logic      close_run;
  logic      better;

  // A run closes on the first taken page after it, or at the end of the pass.
  assign close_run = (ctl.step && !ctl.page_free && prev_free) || (ctl.finish && prev_free);

  always_comb begin
    better = ({{(USED_W-CNT_W){1'b0}}, cur_len} >= need) &&
             (!res.found ||
              (!best_fit && (cur_len > res.best_len)) ||
              (best_fit && (cur_len < res.best_len)));
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      prev_free      <= 1'b0;
      cur_start      <= '0;
      cur_len        <= '0;
      res            <= '0;
    end else begin
      if (close_run && better) begin
        res.found      <= 1'b1;
        res.best_start <= cur_start;
        res.best_len   <= cur_len;
      end
      if (ctl.step) begin
        prev_free <= ctl.page_free;
        if (ctl.page_free) begin
          res.frees <= res.frees + 1'b1;
          if (!prev_free) begin
            cur_start <= ctl.page;
            cur_len   <= page_cnt_t'(1);
            res.frags <= res.frags + 1'b1;
          end else begin
            cur_len <= cur_len + 1'b1;
          end
        end
      end
      if (ctl.finish) begin
        prev_free <= 1'b0;
      end
    end
  end

endmodule

@@ design/contiguous_page_allocator_top.sv @@
// Contiguous page allocator. The block owns a pool of 32 pages of 4 KB, each
// free or owned by an 8-bit program id, kept in a single-port-write page RAM.
// A request is taken when start is high and busy is low; command selects add
// (round size_kb up to whole pages and place them at the start of one free
// run), kill (free every page owned by program_id) or fragment count. Every
// request returns exactly one result, shown for a single cycle with done high;
// the receiver cannot stall it, so it must capture the result on that cycle.
// Each request makes one sequential read-modify-write pass over the page RAM,
// one page per cycle, and busy stays high until the result; a successful add
// first writes its pages, one per cycle, before returning it.
// After reset the block clears every page of the page RAM and holds busy high.
// The fit_mode register (0 largest free run, 1 smallest run that fits) is
// written through cfg_we and cfg_wdata and must only change while busy is low
// and no result is pending.
module contiguous_page_allocator_top
  import cpa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          command,
  input  logic [ID_W-1:0]     program_id,
  input  logic [SIZE_W-1:0]   size_kb,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [START_W-1:0]  start_page,
  output logic [USED_W-1:0]   pages_used,
  output logic [FREED_W-1:0]  freed_pages,
  output logic [FRAG_W-1:0]   fragment_count,
  output logic [FREE_W-1:0]   free_pages
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_CHECK,
    S_WRITE
  } state_t;

  state_t state;

  logic              fit_mode;
  page_cnt_t         cnt;
  logic              rd_valid;
  page_idx_t         rd_page;
  page_idx_t         wr_addr;
  page_cnt_t         freed;
  logic [1:0]        cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [USED_W-1:0] used_q;

  logic              ram_we;
  page_idx_t         ram_waddr;
  page_entry_t       ram_wdata;
  page_entry_t       rd_entry;
  logic              issuing;
  logic              match;
  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;

  logic [SIZE_W:0]   size_round;
  logic [USED_W-1:0] used_calc;
  logic              is_add;
  logic              alloc_ok;
  logic              full_run;
  logic [STATUS_W-1:0] status_calc;
  page_cnt_t         frags_calc;
  page_cnt_t         frees_calc;

  assign busy = (state != S_IDLE);

  // Size in pages, rounded up.
  assign size_round = {1'b0, size_kb} + (SIZE_W+1)'(PAGE_KB - 1);
  assign used_calc  = USED_W'(size_round / PAGE_KB);

  // Reads are issued one page per cycle; data comes back from the registered RAM read port.
  assign issuing = (state == S_SCAN) && (cnt < page_cnt_t'(NUM_PAGES));

  // A kill frees a page on the same pass that reads it.
  assign match = rd_valid && (cmd_q == CMD_KILL) && rd_entry.taken && (rd_entry.owner == id_q);

  always_comb begin
    scan_ctl.init      = (state == S_IDLE) && start;
    scan_ctl.step      = rd_valid;
    scan_ctl.page_free = !rd_entry.taken || match;
    scan_ctl.page      = rd_page;
    scan_ctl.finish    = (state == S_FINISH);
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_page;
    ram_wdata = '{taken: 1'b0, owner: rd_entry.owner};
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt[PAGE_W-1:0];
        ram_wdata = '0;
      end
      S_SCAN: begin
        ram_we = match;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = wr_addr;
        ram_wdata = '{taken: 1'b1, owner: id_q};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  cpa_page_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[PAGE_W-1:0]),
    .rdata (rd_entry)
  );

  cpa_run_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .need     (used_q),
    .best_fit (fit_mode),
    .res      (scan_res)
  );

  // The scanner counts the pool as it stood before an add; an add placed at
  // the head of a run removes that run only when it fills it completely.
  always_comb begin
    is_add   = (cmd_q == CMD_ADD);
    alloc_ok = is_add && (used_q != '0) && scan_res.found;
    full_run = ({{(USED_W-CNT_W){1'b0}}, scan_res.best_len} == used_q);
    if (is_add && (used_q == '0)) begin
      status_calc = ST_ZERO;
    end else if (is_add && !scan_res.found) begin
      status_calc = ST_NO_FIT;
    end else begin
      status_calc = ST_OK;
    end
    frags_calc = scan_res.frags - page_cnt_t'(alloc_ok && full_run);
    frees_calc = scan_res.frees - (alloc_ok ? used_q[CNT_W-1:0] : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
      fit_mode <= 1'b0;
    end else begin
      done     <= 1'b0;
      rd_valid <= issuing;
      rd_page  <= cnt[PAGE_W-1:0];
      if (cfg_we) begin
        fit_mode <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == page_cnt_t'(NUM_PAGES - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q  <= command;
            id_q   <= program_id;
            used_q <= (command == CMD_ADD) ? used_calc : '0;
            cnt    <= '0;
            freed  <= '0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issuing) begin
            cnt <= cnt + 1'b1;
          end
          if (match) begin
            freed <= freed + 1'b1;
          end
          if (rd_valid && (rd_page == page_idx_t'(NUM_PAGES - 1))) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (alloc_ok) begin
            wr_addr <= scan_res.best_start;
            cnt     <= '0;
            state   <= S_WRITE;
          end else begin
            status         <= status_calc;
            start_page     <= '0;
            pages_used     <= used_q;
            freed_pages    <= FREED_W'(freed);
            fragment_count <= FRAG_W'(frags_calc);
            free_pages     <= FREE_W'(frees_calc);
            done           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        S_WRITE: begin
          wr_addr <= wr_addr + 1'b1;
          cnt     <= cnt + 1'b1;
          if ({{(USED_W-CNT_W){1'b0}}, cnt} == (used_q - USED_W'(1))) begin
            status         <= status_calc;
            start_page     <= START_W'(scan_res.best_start);
            pages_used     <= used_q;
            freed_pages    <= '0;
            fragment_count <= FRAG_W'(frags_calc);
            free_pages     <= FREE_W'(frees_calc);
            done           <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ design/cpa_checker.sv @@
module cpa_checker
  import cpa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [STATUS_W-1:0] status,
  input logic [START_W-1:0]  start_page,
  input logic [FREED_W-1:0]  freed_pages,
  input logic [FRAG_W-1:0]   fragment_count,
  input logic [FREE_W-1:0]   free_pages
);

  // An accepted request keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

  // A result only follows work in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  // One result per request: the done strobe is never held high.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

  // Every free run holds at least one free page.
  a_frag_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, fragment_count} <= free_pages))
    else $error("more fragments than free pages");

  // A failed add reports no placement and frees nothing.
  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status != ST_OK)) |-> ((start_page == '0) && (freed_pages == '0)))
    else $error("failed request reports a placement or freed pages");

endmodule

bind contiguous_page_allocator_top cpa_checker u_cpa_checker (.*);
